/* hdl/lrf_pkg.sv */
`default_nettype none

package lrf_pkg;

	// Widths of the request and result fields.
	localparam int ID_W = 6;
	localparam int OCC_W = 7;
	localparam int ID_SPACE = 1 << ID_W;
	localparam int DEF_NUM_FRAMES = 64;

	// Request codes.
	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_VICTIM = 2'd1,
		REQ_ERASE  = 2'd2
	} req_code_t;

	// One request.
	typedef struct packed {
		logic [1:0]      req_type;
		logic [ID_W-1:0] frame_id;
	} request_t;

	// One result.
	typedef struct packed {
		logic             ok;
		logic [ID_W-1:0]  victim_id;
		logic [OCC_W-1:0] occupancy;
	} result_t;

	// Update applied to every cell of the row at once.
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_TOUCH = 3'd1,
		OP_PUSH  = 3'd2,
		OP_POP   = 3'd3,
		OP_ERASE = 3'd4
	} cell_op_t;

	// Broadcast control from the sequencer to the cell row.
	typedef struct packed {
		cell_op_t        op;
		logic [ID_W-1:0] id;
	} cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/lrf_cell.sv */
`default_nettype none

module lrf_cell (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire lrf_pkg::cell_ctrl_t ctrl,
	input  wire [lrf_pkg::ID_W-1:0] prev_key,
	input  wire                    prev_valid,
	input  wire [lrf_pkg::ID_W-1:0] next_key,
	input  wire                    next_valid,
	input  wire                    hit_in,
	output logic                   hit_out,
	input  wire [lrf_pkg::ID_W-1:0] victim_in,
	output logic [lrf_pkg::ID_W-1:0] victim_out,
	output logic [lrf_pkg::ID_W-1:0] key,
	output logic                   valid
);
	import lrf_pkg::*;

	logic [ID_W-1:0] key_q;
	logic            valid_q;
	logic            match;
	logic            tail;

	assign key = key_q;
	assign valid = valid_q;

	// Compare this entry against the requested frame and extend the hit chain.
	assign match = valid_q && (key_q == ctrl.id);
	assign hit_out = hit_in | match;

	// The least recent entry is the last valid cell of the row.
	assign tail = valid_q && !next_valid;
	assign victim_out = victim_in | (tail ? key_q : '0);

	// Entry keys carry no reset; they are only read while valid.
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_TOUCH: begin
				if (!hit_in) key_q <= prev_key;
			end
			OP_PUSH: key_q <= prev_key;
			OP_ERASE: begin
				if (hit_in || match) key_q <= next_key;
			end
			default: key_q <= key_q;
		endcase
	end

	// Valid bit follows the shift direction of the keys.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_PUSH: valid_q <= prev_valid;
				OP_POP: begin
					if (tail) valid_q <= 1'b0;
				end
				OP_ERASE: begin
					if (hit_in || match) valid_q <= next_valid;
				end
				default: valid_q <= valid_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hdl/lru_frame_replacer_unit.sv */
`default_nettype none

// LRU frame replacer. Holds a recency-ordered set of distinct frame numbers
// in a row of cells, most recent first. A request is taken when start is
// high and busy is low; busy is then high for one cycle while the whole row
// compares and shifts at once, and in the cycle after that done is high for
// exactly one cycle with the result, which must be taken then. A new request
// may be issued in the same cycle that done is shown. The row length is the
// smaller of NUM_FRAMES and 64, and the compare, hit chain and shift across
// that row all happen within the cycle that busy is high.
module lru_frame_replacer_unit #(
	parameter int NUM_FRAMES = lrf_pkg::DEF_NUM_FRAMES
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire lrf_pkg::request_t request,
	output logic               busy,
	output logic               done,
	output lrf_pkg::result_t   result
);
	import lrf_pkg::*;

	localparam int SLOTS = (NUM_FRAMES < ID_SPACE) ? NUM_FRAMES : ID_SPACE;
	localparam int CNT_W = $clog2(SLOTS + 1);

	request_t        req_q;
	logic            busy_q;
	logic            done_q;
	result_t         result_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;

	cell_ctrl_t      ctrl;
	logic            in_range;
	logic            full;
	logic            empty;

	logic [ID_W-1:0] key_w [SLOTS];
	logic [SLOTS-1:0] valid_w;
	logic [SLOTS:0]  hit_w;
	logic [ID_W-1:0] vic_w [SLOTS+1];

	assign busy = busy_q;
	assign done = done_q;
	assign result = result_q;

	// Request register and sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start && !busy_q;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) req_q <= request;
	end

	// Decide the row update from the request and the row's hit.
	assign in_range = (NUM_FRAMES >= ID_SPACE) || (32'(req_q.frame_id) < NUM_FRAMES);
	assign full = (count_q == CNT_W'(SLOTS));
	assign empty = (count_q == '0);

	always_comb begin
		ctrl.id = req_q.frame_id;
		ctrl.op = OP_NONE;
		count_d = count_q;
		if (busy_q) begin
			case (req_q.req_type)
				REQ_INSERT: begin
					if (in_range && hit_w[SLOTS]) begin
						ctrl.op = OP_TOUCH;
					end else if (in_range && !full) begin
						ctrl.op = OP_PUSH;
						count_d = count_q + 1'b1;
					end
				end
				REQ_VICTIM: begin
					if (!empty) begin
						ctrl.op = OP_POP;
						count_d = count_q - 1'b1;
					end
				end
				REQ_ERASE: begin
					if (hit_w[SLOTS]) begin
						ctrl.op = OP_ERASE;
						count_d = count_q - 1'b1;
					end
				end
				default: ctrl.op = OP_NONE;
			endcase
		end
	end

	// Occupancy count and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			result_q.ok <= (ctrl.op != OP_NONE);
			result_q.victim_id <= (ctrl.op == OP_POP) ? vic_w[SLOTS] : '0;
			result_q.occupancy <= OCC_W'(count_d);
		end
	end

	// The cell row, most recent entry at cell zero.
	assign hit_w[0] = 1'b0;
	assign vic_w[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic [ID_W-1:0] prev_key;
		logic            prev_valid;
		logic [ID_W-1:0] next_key;
		logic            next_valid;

		if (i == 0) begin : g_head
			assign prev_key = req_q.frame_id;
			assign prev_valid = 1'b1;
		end else begin : g_body
			assign prev_key = key_w[i-1];
			assign prev_valid = valid_w[i-1];
		end

		if (i == SLOTS - 1) begin : g_end
			assign next_key = '0;
			assign next_valid = 1'b0;
		end else begin : g_mid
			assign next_key = key_w[i+1];
			assign next_valid = valid_w[i+1];
		end

		lrf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_key   (prev_key),
			.prev_valid (prev_valid),
			.next_key   (next_key),
			.next_valid (next_valid),
			.hit_in     (hit_w[i]),
			.hit_out    (hit_w[i+1]),
			.victim_in  (vic_w[i]),
			.victim_out (vic_w[i+1]),
			.key        (key_w[i]),
			.valid      (valid_w[i])
		);
	end

	// The valid cells always form a prefix whose length is the count.
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_w) == 32'(count_q))
		else $error("valid cells disagree with occupancy count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("occupancy count above row length");

	a_done_follows_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> done_q && !busy_q)
		else $error("result not issued the cycle after processing");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy_q |=> busy_q)
		else $error("accepted request did not start processing");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |=> $stable(count_q))
		else $error("occupancy changed without a request");

endmodule

`default_nettype wire
